[rtl/zsce_pkg.sv]
package zsce_pkg;

   localparam int CsrIndexWidth = 3;

   localparam logic [CsrIndexWidth-1:0] CSR_VARIANT     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_X_OFFSET    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_Y_OFFSET    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PRIO_MASK_0 = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_PRIO_MASK_1 = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_PRIO_MASK_2 = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_PRIO_MASK_3 = 3'd6;

   localparam logic signed [11:0] FOLD_LIMIT = 12'sh340;
   localparam logic signed [11:0] FOLD_SPAN  = 12'sh400;

   typedef struct packed {
      logic [31:0] attr_word_a;
      logic [31:0] attr_word_c;
      logic [31:0] attr_word_d;
   } req_word_type;

   typedef struct packed {
      logic [17:0]        map_address;
      logic [7:0]         chunk_color;
      logic               out_flip_x;
      logic               out_flip_y;
      logic signed [11:0] pos_x;
      logic signed [11:0] pos_y;
      logic [6:0]         chunk_width;
      logic [6:0]         chunk_height;
      logic [31:0]        priority_mask;
      logic               last_chunk;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic tile_zero;
      logic last;
   } dp_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

endpackage

[rtl/zsce_ctrl.sv]
module zsce_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  zsce_pkg::dp_status_type status,
   output zsce_pkg::ctrl_cmd_type  cmd
);
   import zsce_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The output register can take a new word when empty or when its word leaves now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!status.tile_zero) state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (out_free) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               if (status.last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

[rtl/zsce_datapath.sv]
module zsce_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [zsce_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [31:0]                         csr_wdata,
   input  zsce_pkg::req_word_type               req_data,
   output zsce_pkg::rsp_word_type               rsp_data,
   input  zsce_pkg::ctrl_cmd_type               cmd,
   output zsce_pkg::dp_status_type              status
);
   import zsce_pkg::*;

   // Configuration registers.
   logic               variant_ff;
   logic signed [10:0] x_offset_ff;
   logic signed [10:0] y_offset_ff;
   logic [31:0]        prio_mask_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         variant_ff  <= 1'b0;
         x_offset_ff <= '0;
         y_offset_ff <= '0;
         for (int i = 0; i < 4; i++) prio_mask_ff[i] <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_VARIANT:     variant_ff      <= csr_wdata[0];
            CSR_X_OFFSET:    x_offset_ff     <= csr_wdata[10:0];
            CSR_Y_OFFSET:    y_offset_ff     <= csr_wdata[10:0];
            CSR_PRIO_MASK_0: prio_mask_ff[0] <= csr_wdata;
            CSR_PRIO_MASK_1: prio_mask_ff[1] <= csr_wdata;
            CSR_PRIO_MASK_2: prio_mask_ff[2] <= csr_wdata;
            CSR_PRIO_MASK_3: prio_mask_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Decode of the incoming word.
   logic               in_fx, in_fy, in_big;
   logic [15:0]        in_tile;
   logic [1:0]         in_prio;
   logic [7:0]         in_colour;
   logic [9:0]         in_x, in_y, in_y_sense;
   logic [7:0]         in_zoom_x, in_zoom_y;
   logic [7:0]         in_col;
   logic [31:0]        in_mask;
   logic signed [11:0] y_sum, y_fold, x_fold, x_base;

   always_comb begin
      in_fx     = req_data.attr_word_a[23];
      in_zoom_x = {1'b0, req_data.attr_word_a[22:16]} + 8'd1;
      in_tile   = variant_ff ? req_data.attr_word_a[15:0]
                             : {1'b0, req_data.attr_word_a[14:0]};
      in_prio   = req_data.attr_word_c[19:18];
      in_colour = req_data.attr_word_c[17:10];
      in_x      = req_data.attr_word_c[9:0];
      in_big    = req_data.attr_word_d[18];
      in_zoom_y = {1'b0, req_data.attr_word_d[16:10]} + 8'd1;
      in_y      = req_data.attr_word_d[9:0];

      // Priority bits land on colour bits 7:6 before the halving.
      in_col = {~variant_ff, in_colour[7:1] | {in_prio, 5'd0}};
      if (variant_ff) begin
         in_fy      = ~req_data.attr_word_d[17];
         in_y_sense = in_y;
         in_mask    = ~32'd1 << prio_mask_ff[in_prio][3:0];
      end else begin
         in_fy      = req_data.attr_word_d[17];
         in_y_sense = 10'd0 - in_y;
         in_mask    = prio_mask_ff[in_prio];
      end

      y_sum  = $signed({2'b00, in_y_sense}) + 12'(y_offset_ff);
      y_fold = (y_sum > FOLD_LIMIT) ? y_sum - FOLD_SPAN : y_sum;
      x_fold = $signed({2'b00, in_x});
      if (x_fold > FOLD_LIMIT) x_fold = x_fold - FOLD_SPAN;
      x_base = x_fold - 12'(x_offset_ff);
   end

   // Per-sprite registers.
   logic               fx_ff, fy_ff, big_ff;
   logic [15:0]        tile_ff;
   logic [7:0]         zoom_x_ff, zoom_y_ff, col_ff;
   logic [31:0]        mask_ff;
   logic signed [11:0] base_x_ff, base_y_ff;
   logic [3:0]         chunk_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         fx_ff     <= in_fx;
         fy_ff     <= in_fy;
         big_ff    <= in_big;
         tile_ff   <= in_tile;
         zoom_x_ff <= in_zoom_x;
         zoom_y_ff <= in_zoom_y;
         col_ff    <= in_col;
         mask_ff   <= in_mask;
         base_x_ff <= x_base;
         base_y_ff <= y_fold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) chunk_ff <= '0;
      else if (cmd.emit)     chunk_ff <= chunk_ff + 4'd1;
   end

   // Chunk geometry for the current column k and row j.
   logic [1:0]  col_k, row_j, map_px, map_py;
   logic [9:0]  kz_x, kz_y, kz1_x, kz1_y;
   logic [6:0]  ox, oy, ox1, oy1;
   logic [17:0] addr;
   logic        last;

   always_comb begin
      col_k  = big_ff ? chunk_ff[1:0] : {1'b0, chunk_ff[0]};
      row_j  = big_ff ? chunk_ff[3:2] : {1'b0, chunk_ff[1]};
      map_px = col_k ^ {big_ff & fx_ff, fx_ff};
      map_py = row_j ^ {big_ff & fy_ff, fy_ff};
      kz_x   = 10'(col_k * zoom_x_ff);
      kz_y   = 10'(row_j * zoom_y_ff);
      kz1_x  = kz_x + {2'b00, zoom_x_ff};
      kz1_y  = kz_y + {2'b00, zoom_y_ff};
      // Dividing by the chunks per side is a shift of one or two.
      ox     = big_ff ? kz_x[8:2]  : kz_x[7:1];
      oy     = big_ff ? kz_y[8:2]  : kz_y[7:1];
      ox1    = big_ff ? kz1_x[8:2] : kz1_x[7:1];
      oy1    = big_ff ? kz1_y[8:2] : kz1_y[7:1];
      addr   = {tile_ff, 2'b00} + {16'd0, map_px}
             + (big_ff ? {14'd0, map_py, 2'b00} : {15'd0, map_py, 1'b0});
      last   = big_ff ? (chunk_ff == 4'd15) : (chunk_ff == 4'd3);
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data.map_address   <= addr;
         rsp_data.chunk_color   <= col_ff;
         rsp_data.out_flip_x    <= ~fx_ff;
         rsp_data.out_flip_y    <= fy_ff;
         rsp_data.pos_x         <= base_x_ff + $signed({5'd0, ox});
         rsp_data.pos_y         <= base_y_ff + $signed({5'd0, oy});
         rsp_data.chunk_width   <= ox1 - ox;
         rsp_data.chunk_height  <= oy1 - oy;
         rsp_data.priority_mask <= mask_ff;
         rsp_data.last_chunk    <= last;
      end
   end

   assign status.tile_zero = (in_tile == 16'd0);
   assign status.last      = last;

endmodule

[rtl/zoomed_sprite_chunk_expander_core.sv]
// Channel   Ports                           Direction  Word
// request   req_valid req_stall req_data    in         three sprite attribute words
// response  rsp_valid rsp_stall rsp_data    out        one zoomed chunk
// config    csr_wr_en csr_index csr_wdata   in         register write, no read-back
//
// A sprite entry is loaded first, then emits 4 (small) or 16 (large) chunks,
// one per cycle from the chunk counter while the output register is free.
// An entry with a zero tile is taken and gives nothing.
// Reset is synchronous and clears the controller, the output valid, the configuration registers and the chunk counter.
// A stalled response holds the chunk sequencer; the next entry is taken while
// the last chunk still waits in the output register.
module zoomed_sprite_chunk_expander_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  zsce_pkg::req_word_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output zsce_pkg::rsp_word_type              rsp_data,
   input  logic                               csr_wr_en,
   input  logic [zsce_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]                        csr_wdata
);
   import zsce_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   zsce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   zsce_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

[rtl/zsce_checker.sv]
module zsce_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input zsce_pkg::req_word_type req_data,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input zsce_pkg::rsp_word_type rsp_data
);
   import zsce_pkg::*;

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // No word is left in the output register after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response word changed");

   // A sprite with a nonzero low tile field always produces chunks.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.attr_word_a[14:0] != 15'd0) |=> req_stall)
      else $error("request not stalled while expanding");

   a_zero_tile_idle: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.attr_word_a[15:0] == 16'd0) |=> !req_stall)
      else $error("zero tile entry held the request side");

   a_mid_sprite_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last_chunk) |-> req_stall)
      else $error("new entry taken before the sprite was finished");

endmodule

bind zoomed_sprite_chunk_expander_core zsce_checker u_zsce_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/sv/zoomed_sprite_chunk_expander_core_tb.sv]
`timescale 1ns / 100ps

import zsce_pkg::*;

class chunk_scoreboard;
   logic         variant;
   int           x_offset;
   int           y_offset;
   logic [31:0]  prio_mask [4];
   rsp_word_type expected_chunks [$];
   int           failures;

   function new();
      variant   = 1'b0;
      x_offset  = 0;
      y_offset  = 0;
      prio_mask = '{default: 32'h0};
      failures  = 0;
   endfunction

   function void set_register(logic [CsrIndexWidth-1:0] idx, logic [31:0] val);
      logic signed [10:0] off11;
      off11 = val[10:0];
      case (idx)
         CSR_VARIANT:     variant = val[0];
         CSR_X_OFFSET:    x_offset = off11;
         CSR_Y_OFFSET:    y_offset = off11;
         CSR_PRIO_MASK_0: prio_mask[0] = val;
         CSR_PRIO_MASK_1: prio_mask[1] = val;
         CSR_PRIO_MASK_2: prio_mask[2] = val;
         CSR_PRIO_MASK_3: prio_mask[3] = val;
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_chunks.size();
   endfunction

   // Expands one accepted sprite entry into its chunk words, row by row.
   function void note_entry(req_word_type w);
      rsp_word_type chunk;
      logic         flip_x, flip_y, big_sprite;
      logic [1:0]   prio;
      logic [31:0]  tile, color, mask, addr;
      int           zoom_x, zoom_y, x, y, dim, shift;
      int           row, col, px, py, ox, oy, sum_x, sum_y;

      flip_x     = w.attr_word_a[23];
      zoom_x     = w.attr_word_a[22:16] + 1;
      tile       = variant ? {16'h0, w.attr_word_a[15:0]} : {17'h0, w.attr_word_a[14:0]};
      prio       = w.attr_word_c[19:18];
      x          = w.attr_word_c[9:0];
      big_sprite = w.attr_word_d[18];
      flip_y     = w.attr_word_d[17];
      zoom_y     = w.attr_word_d[16:10] + 1;
      y          = w.attr_word_d[9:0];

      if (tile == 32'h0) return;

      if (variant) begin
         color  = ({24'h0, w.attr_word_c[17:10]} | ({30'h0, prio} << 6)) >> 1;
         flip_y = ~flip_y;
         mask   = 32'hFFFF_FFFE << prio_mask[prio][3:0];
      end else begin
         color = ({24'h0, w.attr_word_c[17:10]} | 32'h100 | ({30'h0, prio} << 6)) >> 1;
         y     = (32'h400 - y) & 32'h3FF;
         mask  = prio_mask[prio];
      end

      y = y + y_offset;
      if (x > int'(FOLD_LIMIT)) x = x - int'(FOLD_SPAN);
      if (y > int'(FOLD_LIMIT)) y = y - int'(FOLD_SPAN);
      x = x - x_offset;

      dim   = big_sprite ? 4 : 2;
      shift = big_sprite ? 2 : 1;
      for (row = 0; row < dim; row++) begin
         for (col = 0; col < dim; col++) begin
            px    = flip_x ? (dim - 1 - col) : col;
            py    = flip_y ? (dim - 1 - row) : row;
            addr  = (tile << 2) + px + (py << shift);
            ox    = (col * zoom_x) / dim;
            oy    = (row * zoom_y) / dim;
            sum_x = x + ox;
            sum_y = y + oy;
            chunk.map_address   = addr[17:0];
            chunk.chunk_color   = color[7:0];
            chunk.out_flip_x    = ~flip_x;
            chunk.out_flip_y    = flip_y;
            chunk.pos_x         = sum_x[11:0];
            chunk.pos_y         = sum_y[11:0];
            chunk.chunk_width   = 7'(((col + 1) * zoom_x) / dim - ox);
            chunk.chunk_height  = 7'(((row + 1) * zoom_y) / dim - oy);
            chunk.priority_mask = mask;
            chunk.last_chunk    = (row == dim - 1) && (col == dim - 1);
            expected_chunks.push_back(chunk);
         end
      end
   endfunction

   function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   function void check_chunk(rsp_word_type got);
      rsp_word_type want;
      if (expected_chunks.size() == 0) begin
         $error("chunk word arrived with none outstanding: 0x%0h", got);
         failures++;
         return;
      end
      want = expected_chunks.pop_front();
      compare_field("map_address", want.map_address, got.map_address);
      compare_field("chunk_color", want.chunk_color, got.chunk_color);
      compare_field("out_flip_x", want.out_flip_x, got.out_flip_x);
      compare_field("out_flip_y", want.out_flip_y, got.out_flip_y);
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("chunk_width", want.chunk_width, got.chunk_width);
      compare_field("chunk_height", want.chunk_height, got.chunk_height);
      compare_field("priority_mask", want.priority_mask, got.priority_mask);
      compare_field("last_chunk", want.last_chunk, got.last_chunk);
   endfunction
endclass

module zoomed_sprite_chunk_expander_core_tb;

   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES  = 24;
   localparam int TIMEOUT_CYCLES = 400000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_word_type             req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_word_type             rsp_data;
   logic                     csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [31:0]              csr_wdata = '0;

   chunk_scoreboard board = new();
   bit              idle_on = 1'b1;
   int              stall_left = 0;
   int              cycle_count = 0;

   zoomed_sprite_chunk_expander_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= TIMEOUT_CYCLES) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic int idle_burst();
      if (idle_on && $urandom_range(0, 5) == 0) return $urandom_range(1, 17);
      return 0;
   endfunction

   always @(negedge clock) begin
      if (stall_left == 0) stall_left = idle_burst();
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_chunk(rsp_data);
   end

   task automatic send_entry(req_word_type w);
      int gap;
      gap = idle_burst();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_entry(w);
   endtask

   // Zero-tile entries produce nothing, so an empty queue does not mean the
   // block is idle; allow a full entry time on top.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.set_register(idx, val);
   endtask

   task automatic program_registers(logic [31:0] variant_val, logic [31:0] x_off,
                                    logic [31:0] y_off, logic [31:0] m0,
                                    logic [31:0] m1, logic [31:0] m2, logic [31:0] m3);
      write_csr(CSR_VARIANT, variant_val);
      write_csr(CSR_X_OFFSET, x_off);
      write_csr(CSR_Y_OFFSET, y_off);
      write_csr(CSR_PRIO_MASK_0, m0);
      write_csr(CSR_PRIO_MASK_1, m1);
      write_csr(CSR_PRIO_MASK_2, m2);
      write_csr(CSR_PRIO_MASK_3, m3);
      write_csr(CSR_UNUSED, $urandom);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] random_offset();
      case ($urandom_range(0, 3))
         0: return 32'hFFFF_FC00;
         1: return 32'h0000_03FF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] random_mask();
      case ($urandom_range(0, 4))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_word_type random_entry();
      req_word_type w;
      w.attr_word_a = $urandom;
      w.attr_word_c = $urandom;
      w.attr_word_d = $urandom;
      case ($urandom_range(0, 11))
         0: w.attr_word_a[15:0] = 16'h0000;
         1: w.attr_word_a[14:0] = 15'h0000;
         2: w.attr_word_a[15:0] = 16'hFFFF;
         3: w.attr_word_a[22:16] = 7'h7F;
         4: w.attr_word_d[16:10] = 7'h00;
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      int phase;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Reset configuration, first form.
      send_entry(req_word_type'{32'h0000_0001, 32'h0000_0000, 32'h0000_0000});
      send_entry(req_word_type'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      send_entry(req_word_type'{32'h00FF_0000, 32'h0000_0000, 32'h0000_0000});
      send_entry(req_word_type'{32'h0000_8000, 32'h0000_0000, 32'h0000_0000});
      send_entry(req_word_type'{32'h0000_7FFF, 32'h0000_0341, 32'h0004_0001});
      settle();

      // Second form with priority levels, including one with high bits set.
      program_registers(32'h1, 32'hFFFF_FC00, 32'h0000_03FF,
                        32'h0000_0000, 32'h0000_000F, 32'hFFFF_FFF7, 32'h8000_0005);
      send_entry(req_word_type'{32'hFFFF_FFFF, 32'h0000_0000, 32'h0004_0000});
      send_entry(req_word_type'{32'h0000_8000, 32'h0004_0340, 32'h0000_0340});
      send_entry(req_word_type'{32'h0080_0000, 32'h0008_0000, 32'h0000_0000});
      send_entry(req_word_type'{32'h007F_0001, 32'h000C_03FF, 32'h0003_FFFF});
      send_entry(req_word_type'{32'h0000_FFFF, 32'h0008_0000, 32'h0002_0000});
      settle();

      program_registers(32'h0, 32'h0000_03FF, 32'hFFFF_FC00,
                        32'hFFFF_FFFF, 32'h0000_0000, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
      send_entry(req_word_type'{32'h0080_1234, 32'h0004_0000, 32'h0000_0000});
      send_entry(req_word_type'{32'h0000_4000, 32'h000C_0200, 32'h0001_FC00});
      send_entry(req_word_type'{32'h0000_7FFF, 32'h0008_03FF, 32'h0006_0000});
      send_entry(req_word_type'{32'h0000_0001, 32'h0000_0000, 32'h0000_0000});
      send_entry(req_word_type'{32'hFFFF_8000, 32'h0000_0000, 32'h0000_0000});

      for (phase = 0; phase < 4; phase++) begin
         settle();
         if (phase == 3) idle_on = 1'b0;
         program_registers($urandom_range(0, 1), random_offset(), random_offset(),
                           random_mask(), random_mask(), random_mask(), random_mask());
         repeat (25) send_entry(random_entry());
      end

      settle();
      if (board.failures == 0 && board.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/zsce_pkg.sv
rtl/zsce_ctrl.sv
rtl/zsce_datapath.sv
rtl/zoomed_sprite_chunk_expander_core.sv
rtl/zsce_checker.sv
tb/sv/zoomed_sprite_chunk_expander_core_tb.sv
